// File: src/icc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icc_pkg
// Shared types, constants and helpers for the identifier case converter.
// ----------------------------------------------------------------------------
package icc_pkg;

    localparam int ICC_FRAME_BYTES = 64;
    localparam int ICC_PADDR_W     = 4;
    localparam int ICC_ERR_LEN     = 3;

    localparam logic [7:0] CHR_SNAKE  = 8'h53;
    localparam logic [7:0] CHR_CAMEL  = 8'h43;
    localparam logic [7:0] CHR_PASCAL = 8'h50;
    localparam logic [7:0] CHR_US     = 8'h5f;
    localparam logic [7:0] CHR_SP     = 8'h20;
    localparam logic [7:0] CHR_E      = 8'h45;
    localparam logic [7:0] CHR_ZERO   = 8'h30;
    localparam logic [7:0] CASE_SHIFT = 8'd32;

    localparam logic [7:0] RST_END_MARKER   = 8'd0;
    localparam logic [3:0] RST_MAX_WORD_LEN = 4'd10;
    localparam logic [4:0] RST_MIN_WORDS    = 5'd1;
    localparam logic [4:0] RST_MAX_WORDS    = 5'd15;

    typedef enum logic [1:0] {
        REG_END_MARKER   = 2'd0,
        REG_MAX_WORD_LEN = 2'd1,
        REG_MIN_WORDS    = 2'd2,
        REG_MAX_WORDS    = 2'd3
    } reg_index_t;

    typedef enum logic [1:0] {
        MODE_PASCAL = 2'd0,
        MODE_CAMEL  = 2'd1,
        MODE_SNAKE  = 2'd2
    } case_mode_t;

    typedef enum logic [1:0] {
        PH_CMD   = 2'd0,
        PH_START = 2'd1,
        PH_WORD  = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        ERR_NONE = 2'd0,
        ERR_DATA = 2'd1,
        ERR_CMD  = 2'd2
    } err_t;

    typedef enum logic [1:0] {
        DESC_TEXT     = 2'd0,
        DESC_ERR_DATA = 2'd1,
        DESC_ERR_CMD  = 2'd2
    } desc_kind_t;

    typedef struct packed {
        logic [7:0] end_marker;
        logic [3:0] max_word_len;
        logic [4:0] min_words;
        logic [4:0] max_words;
    } cfg_t;

    typedef struct packed {
        desc_kind_t kind;
        logic       camel;
        logic       bank;
    } frame_desc_t;

    function automatic logic is_upper(input logic [7:0] c);
        return (c >= 8'h41) && (c <= 8'h5a);
    endfunction

    function automatic logic is_lower(input logic [7:0] c);
        return (c >= 8'h61) && (c <= 8'h7a);
    endfunction

endpackage

// File: src/icc_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icc_if
// Valid/ready channels for the input word and the output word.
// ----------------------------------------------------------------------------
interface icc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink (input valid, input in_byte, output ready);
endinterface

interface icc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_last;

    modport source (output valid, output out_byte, output out_last, input ready);
    modport sink (input valid, input out_byte, input out_last, output ready);
endinterface

// File: src/icc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icc_front
// Frame parser: checks each input word, writes converted text to the frame
// buffer and hands a descriptor to the queue at the end marker.
// ----------------------------------------------------------------------------
module icc_front
    import icc_pkg::*;
#(
    parameter int FRAME_BYTES = ICC_FRAME_BYTES,
    localparam int AW = $clog2(FRAME_BYTES),
    localparam int CW = $clog2(FRAME_BYTES + 1)
)
(
    input  logic         clk,
    input  logic         rst_n,
    icc_in_if.sink       in_ch,
    input  cfg_t         cfg,
    input  logic         q_full,
    output logic         wr_en,
    output logic [AW:0]  wr_addr,
    output logic [7:0]   wr_data,
    output logic         desc_push,
    output frame_desc_t  desc,
    output logic [CW-1:0] desc_len
);

    phase_t       phase_reg, phase_next;
    case_mode_t   mode_reg, mode_next;
    err_t         err_reg, err_next;
    logic [3:0]   wlen_reg, wlen_next;
    logic [4:0]   wtot_reg, wtot_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic         bank_reg, bank_next;
    logic         pend_valid_reg, pend_valid_next;
    logic [AW:0]  pend_addr_reg, pend_addr_next;
    logic [7:0]   pend_data_reg, pend_data_next;

    logic         acc;
    logic [7:0]   b;
    logic         start;
    logic [1:0]   n_push;
    logic [7:0]   d0;
    logic [7:0]   d1;
    logic [7:0]   letter;
    logic [CW:0]  cnt_sum;
    logic [CW-1:0] cnt_plus1;
    desc_kind_t   kind;

    assign acc         = in_ch.valid && in_ch.ready;
    assign b           = in_ch.in_byte;
    assign in_ch.ready = !q_full && !pend_valid_reg;
    assign cnt_plus1   = cnt_reg + CW'(1);

    // next state
    always_comb
    begin
        phase_next = phase_reg;
        mode_next  = mode_reg;
        err_next   = err_reg;
        wlen_next  = wlen_reg;
        wtot_next  = wtot_reg;
        cnt_next   = cnt_reg;
        bank_next  = bank_reg;
        n_push     = 2'd0;
        d0         = 8'd0;
        d1         = 8'd0;
        letter     = 8'd0;
        start      = 1'b0;
        cnt_sum    = {1'b0, cnt_reg};
        desc_push  = 1'b0;
        kind       = DESC_TEXT;
        if (acc)
        begin
            if (b == cfg.end_marker)
            begin
                desc_push = 1'b1;
                priority if (phase_reg == PH_CMD || err_reg == ERR_CMD)
                    kind = DESC_ERR_CMD;
                else if (err_reg != ERR_NONE || phase_reg != PH_WORD ||
                         wtot_reg < cfg.min_words)
                    kind = DESC_ERR_DATA;
                else
                    kind = DESC_TEXT;
                phase_next = PH_CMD;
                err_next   = ERR_NONE;
                wlen_next  = 4'd0;
                wtot_next  = 5'd0;
                cnt_next   = '0;
                bank_next  = ~bank_reg;
            end
            else if (phase_reg == PH_CMD)
            begin
                phase_next = PH_START;
                unique case (b)
                    CHR_SNAKE:  mode_next = MODE_SNAKE;
                    CHR_CAMEL:  mode_next = MODE_CAMEL;
                    CHR_PASCAL: mode_next = MODE_PASCAL;
                    default:    err_next  = ERR_CMD;
                endcase
                if (b == CHR_SNAKE || b == CHR_CAMEL || b == CHR_PASCAL)
                begin
                    n_push   = 2'd1;
                    d0       = b;
                    cnt_next = CW'(1);
                end
            end
            else if (err_reg == ERR_NONE)
            begin
                priority if (phase_reg == PH_START)
                    start = 1'b1;
                else if (is_lower(b))
                begin
                    if (wlen_reg >= cfg.max_word_len)
                        err_next = ERR_DATA;
                    else
                    begin
                        wlen_next = wlen_reg + 4'd1;
                        n_push    = 2'd1;
                        d0        = b;
                    end
                end
                else if (b == CHR_US || b == CHR_SP)
                begin
                    phase_next = PH_START;
                    if (mode_reg == MODE_SNAKE)
                    begin
                        n_push = 2'd1;
                        d0     = CHR_US;
                    end
                end
                else if (is_upper(b))
                begin
                    start = 1'b1;
                    if (mode_reg == MODE_SNAKE)
                    begin
                        n_push = 2'd1;
                        d0     = CHR_US;
                    end
                end
                else
                    err_next = ERR_DATA;

                if (start)
                begin
                    priority if (!is_lower(b) && !is_upper(b))
                        err_next = ERR_DATA;
                    else if (wtot_reg >= cfg.max_words || cfg.max_word_len == 4'd0)
                        err_next = ERR_DATA;
                    else
                    begin
                        wtot_next  = wtot_reg + 5'd1;
                        wlen_next  = 4'd1;
                        phase_next = PH_WORD;
                        if (mode_reg == MODE_SNAKE)
                            letter = is_upper(b) ? b + CASE_SHIFT : b;
                        else
                            letter = is_lower(b) ? b - CASE_SHIFT : b;
                        if (n_push == 2'd0)
                        begin
                            d0     = letter;
                            n_push = 2'd1;
                        end
                        else
                        begin
                            d1     = letter;
                            n_push = 2'd2;
                        end
                    end
                end

                cnt_sum = {1'b0, cnt_reg} + (CW+1)'(n_push);
                if (cnt_sum > (CW+1)'(FRAME_BYTES))
                begin
                    err_next = ERR_DATA;
                    n_push   = 2'd0;
                end
                else
                    cnt_next = cnt_sum[CW-1:0];
            end
        end
    end

    // buffer write port and descriptor
    always_comb
    begin
        wr_en           = 1'b0;
        wr_addr         = {bank_reg, cnt_reg[AW-1:0]};
        wr_data         = d0;
        pend_valid_next = 1'b0;
        pend_addr_next  = pend_addr_reg;
        pend_data_next  = pend_data_reg;
        if (pend_valid_reg)
        begin
            wr_en   = 1'b1;
            wr_addr = pend_addr_reg;
            wr_data = pend_data_reg;
        end
        else if (n_push != 2'd0)
        begin
            wr_en = 1'b1;
            if (n_push == 2'd2)
            begin
                pend_valid_next = 1'b1;
                pend_addr_next  = {bank_reg, cnt_plus1[AW-1:0]};
                pend_data_next  = d1;
            end
        end
        desc.kind  = kind;
        desc.camel = (mode_reg == MODE_CAMEL);
        desc.bank  = bank_reg;
        desc_len   = cnt_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_CMD;
            mode_reg       <= MODE_PASCAL;
            err_reg        <= ERR_NONE;
            wlen_reg       <= 4'd0;
            wtot_reg       <= 5'd0;
            cnt_reg        <= '0;
            bank_reg       <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            mode_reg       <= mode_next;
            err_reg        <= err_next;
            wlen_reg       <= wlen_next;
            wtot_reg       <= wtot_next;
            cnt_reg        <= cnt_next;
            bank_reg       <= bank_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_addr_reg <= pend_addr_next;
        pend_data_reg <= pend_data_next;
    end

    a_cmd_empty: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_CMD |-> cnt_reg == '0)
        else $error("buffer not empty while waiting for command");

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(FRAME_BYTES))
        else $error("buffer count beyond frame size");

endmodule

// File: src/icc_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icc_queue
// Two-entry descriptor queue between parser and emitter, one per buffer bank.
// ----------------------------------------------------------------------------
module icc_queue
    import icc_pkg::*;
#(
    parameter int WIDTH = $bits(frame_desc_t)
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic             full,
    output logic             head_valid,
    output logic [WIDTH-1:0] head_data
);

    logic [WIDTH-1:0] entry_reg [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       count_reg;

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head_data  = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            if (push && !pop)
                count_reg <= count_reg + 2'd1;
            else if (pop && !push)
                count_reg <= count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push || pop)
        else $error("descriptor pushed into full queue");

endmodule

// File: src/icc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icc_back
// Frame emitter: holds the two-bank frame buffer and streams a finished
// frame or error text out, one word per cycle while out_ch is ready.
// ----------------------------------------------------------------------------
module icc_back
    import icc_pkg::*;
#(
    parameter int FRAME_BYTES = ICC_FRAME_BYTES,
    localparam int AW = $clog2(FRAME_BYTES),
    localparam int CW = $clog2(FRAME_BYTES + 1)
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  logic [AW:0]   wr_addr,
    input  logic [7:0]    wr_data,
    input  logic          desc_valid,
    input  frame_desc_t   desc,
    input  logic [CW-1:0] desc_len,
    output logic          desc_pop,
    icc_out_if.source     out_ch
);

    logic [7:0]    frame_mem [0:(2 << AW) - 1];
    logic [7:0]    rd_q_reg;
    logic          out_valid_reg;
    logic [CW-1:0] idx_reg;
    logic          last_reg;
    logic          err_sel_reg;
    logic [7:0]    err_byte_reg;
    logic          lower_reg;

    logic          adv;
    logic          issue;
    logic          is_last;
    logic [CW-1:0] n_bytes;
    logic [7:0]    err_char;
    logic [AW:0]   rd_addr;

    assign adv      = !out_valid_reg || out_ch.ready;
    assign issue    = adv && desc_valid;
    assign n_bytes  = (desc.kind == DESC_TEXT) ? desc_len : CW'(ICC_ERR_LEN);
    assign is_last  = (idx_reg + CW'(1)) == n_bytes;
    assign desc_pop = issue && is_last;
    assign rd_addr  = {desc.bank, idx_reg[AW-1:0]};

    always_comb
    begin
        priority if (idx_reg == '0)
            err_char = CHR_E;
        else if (idx_reg == CW'(1))
            err_char = CHR_ZERO;
        else if (desc.kind == DESC_ERR_CMD)
            err_char = CHR_ZERO + 8'd1;
        else
            err_char = CHR_ZERO;
    end

    always_comb
    begin
        out_ch.valid    = out_valid_reg;
        out_ch.out_last = last_reg;
        priority if (err_sel_reg)
            out_ch.out_byte = err_byte_reg;
        else if (lower_reg && is_upper(rd_q_reg))
            out_ch.out_byte = rd_q_reg + CASE_SHIFT;
        else
            out_ch.out_byte = rd_q_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else if (issue)
        begin
            out_valid_reg <= 1'b1;
            idx_reg       <= is_last ? '0 : idx_reg + CW'(1);
        end
        else if (adv)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            last_reg     <= is_last;
            err_sel_reg  <= (desc.kind != DESC_TEXT);
            err_byte_reg <= err_char;
            lower_reg    <= desc.camel && (idx_reg == CW'(1));
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            frame_mem[wr_addr] <= wr_data;
        if (issue && desc.kind == DESC_TEXT)
            rd_q_reg <= frame_mem[rd_addr];
    end

    a_pop_last: assert property (@(posedge clk) disable iff (!rst_n)
        desc_pop |=> out_ch.valid && out_ch.out_last)
        else $error("frame end not marked on final word");

    a_idx_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !desc_valid |-> idx_reg == '0)
        else $error("word index left over without a frame");

    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        desc_valid |-> idx_reg < n_bytes)
        else $error("word index past frame length");

endmodule

// File: src/identifier_case_converter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// identifier_case_converter
// Converts a framed identifier to snake, camel or Pascal case, with a
// register port for the end marker and the word limits.
//
//  port     dir  carries                       handshake
//  in_ch    in   in_byte[7:0]                  valid / ready
//  out_ch   out  out_byte[7:0], out_last       valid / ready
//  apb      in   4 registers at 0x0 .. 0xc     psel / penable, pready high
//
// One input word per cycle; an upper-case word start after a word in snake mode writes
// two buffer entries and holds ready low for one more cycle (single write port).
// Output runs one word per cycle from the buffer read port while out_ch is ready; the
// end marker queues a descriptor, then the first word is registered; error text: 3 words.
// Two buffer banks: besides double writes, input stalls only while two finished frames are queued.
// Reset clears all control state; the frame buffer needs no clearing pass.
// ----------------------------------------------------------------------------
module identifier_case_converter
    import icc_pkg::*;
#(
    parameter int FRAME_BYTES = ICC_FRAME_BYTES
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    icc_in_if.sink                 in_ch,
    icc_out_if.source              out_ch,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [ICC_PADDR_W-1:0] paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    localparam int AW = $clog2(FRAME_BYTES);
    localparam int CW = $clog2(FRAME_BYTES + 1);
    localparam int QW = $bits(frame_desc_t) + CW;

    cfg_t          cfg_reg;
    reg_index_t    reg_sel;
    logic          cfg_wr;

    logic          wr_en;
    logic [AW:0]   wr_addr;
    logic [7:0]    wr_data;
    logic          desc_push;
    frame_desc_t   push_desc;
    logic [CW-1:0] push_len;
    logic          q_full;
    logic          q_valid;
    logic [QW-1:0] q_head;
    logic          desc_pop;
    frame_desc_t   head_desc;
    logic [CW-1:0] head_len;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign reg_sel = reg_index_t'(paddr[3:2]);

    always_comb
    begin
        unique case (reg_sel)
            REG_END_MARKER:   prdata = {24'd0, cfg_reg.end_marker};
            REG_MAX_WORD_LEN: prdata = {28'd0, cfg_reg.max_word_len};
            REG_MIN_WORDS:    prdata = {27'd0, cfg_reg.min_words};
            REG_MAX_WORDS:    prdata = {27'd0, cfg_reg.max_words};
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.end_marker   <= RST_END_MARKER;
            cfg_reg.max_word_len <= RST_MAX_WORD_LEN;
            cfg_reg.min_words    <= RST_MIN_WORDS;
            cfg_reg.max_words    <= RST_MAX_WORDS;
        end
        else if (cfg_wr)
        begin
            unique case (reg_sel)
                REG_END_MARKER:   cfg_reg.end_marker   <= pwdata[7:0];
                REG_MAX_WORD_LEN: cfg_reg.max_word_len <= pwdata[3:0];
                REG_MIN_WORDS:    cfg_reg.min_words    <= pwdata[4:0];
                REG_MAX_WORDS:    cfg_reg.max_words    <= pwdata[4:0];
            endcase
        end
    end

    icc_front #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .cfg       (cfg_reg),
        .q_full    (q_full),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .desc_push (desc_push),
        .desc      (push_desc),
        .desc_len  (push_len)
    );

    icc_queue #(
        .WIDTH (QW)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (desc_push),
        .push_data  ({push_len, push_desc}),
        .pop        (desc_pop),
        .full       (q_full),
        .head_valid (q_valid),
        .head_data  (q_head)
    );

    assign head_desc = frame_desc_t'(q_head[$bits(frame_desc_t)-1:0]);
    assign head_len  = q_head[QW-1:$bits(frame_desc_t)];

    icc_back #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .desc_valid (q_valid),
        .desc       (head_desc),
        .desc_len   (head_len),
        .desc_pop   (desc_pop),
        .out_ch     (out_ch)
    );

endmodule

// File: tb/identifier_case_converter_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// identifier_case_converter_test
// Self-checking bench for the identifier case converter. A short table of
// directed frames covers the error codes, each case mode and the word limits,
// then fixed and randomised register settings drive well-formed, broken and noisy frames.
// Every output word is checked against a typed result or behavioural model of the converter,
// with bursty input and a stalling output side.
// ----------------------------------------------------------------------------
module identifier_case_converter_test
    import icc_pkg::*;
();

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 20;
    localparam int MAX_REPORTS    = 10;
    localparam int RANDOM_PHASES  = 10;
    localparam int FIXED_PHASES   = 6;
    localparam int PHASE_ITEMS    = 30;
    localparam int DIRECTED_COUNT = 14;

    localparam logic [7:0] UC_LO = 8'h41;
    localparam logic [7:0] UC_HI = 8'h5a;
    localparam logic [7:0] LC_LO = 8'h61;
    localparam logic [7:0] LC_HI = 8'h7a;

    // register sets for the first random phases: extremes and end markers that
    // collide with the end, a command byte, a separator and a letter
    localparam logic [7:0] FIXED_END [FIXED_PHASES] =
        '{8'h00, 8'hff, 8'h2e, CHR_SNAKE, CHR_US, 8'h65};
    localparam logic [3:0] FIXED_LEN [FIXED_PHASES] = '{4'd15, 4'd1, 4'd4, 4'd6, 4'd8, 4'd10};
    localparam logic [4:0] FIXED_MIN [FIXED_PHASES] = '{5'd1, 5'd31, 5'd1, 5'd2, 5'd1, 5'd1};
    localparam logic [4:0] FIXED_MAX [FIXED_PHASES] = '{5'd31, 5'd1, 5'd4, 5'd8, 5'd12, 5'd31};

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } out_word_t;

    typedef struct {
        bit         is_write;
        reg_index_t reg_sel;
        logic [7:0] reg_val;
        string      frame_text;
        string      typed_result;
    } directed_row_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [ICC_PADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    icc_in_if  in_ch ();
    icc_out_if out_ch ();

    identifier_case_converter dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // converter model state
    cfg_t        regs_now;
    logic [7:0]  conv_buf [ICC_FRAME_BYTES];
    int          conv_fill;
    phase_t      conv_phase;
    case_mode_t  conv_mode;
    err_t        conv_err;
    logic [3:0]  word_chars;
    logic [4:0]  word_count;
    bit          typed_row;

    out_word_t   awaited_words [$];
    out_word_t   head_word;

    int          inputs_sent;
    int          words_checked;
    int          frames_done;
    int          error_frames;
    int          settings_used;
    int          mismatches;
    int          idle_cycles;
    int          burst_left;

    function automatic void flag_error(input string what);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("ERROR: %s", what);
    endfunction

    function automatic void await_word(input logic [7:0] data, input logic last);
        if (!typed_row)
            awaited_words.push_back('{data, last});
    endfunction

    function automatic void clear_frame();
        conv_fill  = 0;
        conv_phase = PH_CMD;
        word_chars = '0;
        word_count = '0;
        conv_err   = ERR_NONE;
    endfunction

    function automatic void store_char(input logic [7:0] c);
        if (conv_fill >= ICC_FRAME_BYTES)
        begin
            conv_err = ERR_DATA;
            return;
        end
        conv_buf[conv_fill] = c;
        conv_fill++;
    endfunction

    function automatic void open_word(input logic [7:0] c);
        if (!(c inside {[UC_LO:UC_HI]}) && !(c inside {[LC_LO:LC_HI]}))
        begin
            conv_err = ERR_DATA;
            return;
        end
        if (word_count >= regs_now.max_words || regs_now.max_word_len == 4'd0)
        begin
            conv_err = ERR_DATA;
            return;
        end
        word_count++;
        word_chars = 4'd1;
        if (conv_mode == MODE_SNAKE)
            store_char((c inside {[UC_LO:UC_HI]}) ? c + CASE_SHIFT : c);
        else
            store_char((c inside {[LC_LO:LC_HI]}) ? c - CASE_SHIFT : c);
        conv_phase = PH_WORD;
    endfunction

    function automatic void extend_word(input logic [7:0] c);
        if (c inside {[LC_LO:LC_HI]})
        begin
            if (word_chars >= regs_now.max_word_len)
            begin
                conv_err = ERR_DATA;
                return;
            end
            word_chars++;
            store_char(c);
        end
        else if (c == CHR_US || c == CHR_SP)
        begin
            if (conv_mode == MODE_SNAKE)
                store_char(CHR_US);
            conv_phase = PH_START;
        end
        else if (c inside {[UC_LO:UC_HI]})
        begin
            if (conv_mode == MODE_SNAKE)
                store_char(CHR_US);
            if (conv_err == ERR_NONE)
                open_word(c);
        end
        else
            conv_err = ERR_DATA;
    endfunction

    function automatic void await_error(input err_t kind);
        await_word(CHR_E, 1'b0);
        await_word(CHR_ZERO, 1'b0);
        await_word((kind == ERR_CMD) ? CHR_ZERO + 8'd1 : CHR_ZERO, 1'b1);
        error_frames++;
    endfunction

    function automatic void convert_byte(input logic [7:0] b);
        logic [7:0] c;
        if (b == regs_now.end_marker)
        begin
            frames_done++;
            if (conv_phase == PH_CMD)
                await_error(ERR_CMD);
            else
            begin
                if (conv_err == ERR_NONE &&
                    (conv_phase != PH_WORD || word_count < regs_now.min_words))
                    conv_err = ERR_DATA;
                if (conv_err != ERR_NONE)
                    await_error(conv_err);
                else
                    for (int i = 0; i < conv_fill; i++)
                    begin
                        c = conv_buf[i];
                        // camel case lowers the first text character on the way out
                        if (i == 1 && conv_mode == MODE_CAMEL && (c inside {[UC_LO:UC_HI]}))
                            c = c + CASE_SHIFT;
                        await_word(c, i == conv_fill - 1);
                    end
            end
            clear_frame();
            return;
        end
        if (conv_phase == PH_CMD)
        begin
            case (b)
                CHR_SNAKE:  conv_mode = MODE_SNAKE;
                CHR_CAMEL:  conv_mode = MODE_CAMEL;
                CHR_PASCAL: conv_mode = MODE_PASCAL;
                default:    conv_err  = ERR_CMD;
            endcase
            if (conv_err == ERR_NONE)
                store_char(b);
            conv_phase = PH_START;
            return;
        end
        if (conv_err != ERR_NONE)
            return;
        if (conv_phase == PH_START)
            open_word(b);
        else
            extend_word(b);
    endfunction

    // input side: bursts of random length with random gaps
    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0)
            begin
                in_ch.valid   <= 1'b0;
                in_ch.in_byte <= 8'($urandom);
                repeat (gap) @(negedge clk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 10);
        end
        in_ch.valid   <= 1'b1;
        in_ch.in_byte <= b;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        burst_left--;
        inputs_sent++;
        convert_byte(b);
        @(negedge clk);
    endtask

    task automatic write_reg(input reg_index_t sel, input logic [7:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= 32'(val);
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        case (sel)
            REG_END_MARKER:   regs_now.end_marker   = val;
            REG_MAX_WORD_LEN: regs_now.max_word_len = val[3:0];
            REG_MIN_WORDS:    regs_now.min_words    = val[4:0];
            REG_MAX_WORDS:    regs_now.max_words    = val[4:0];
        endcase
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
    endtask

    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        while (awaited_words.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    function automatic logic [7:0] pick_letter(input bit upper);
        return (upper ? UC_LO : LC_LO) + 8'($urandom_range(0, 25));
    endfunction

    task automatic send_frame();
        logic [7:0] frame_q [$];
        int         kind;
        int         n_words;
        int         wlen;
        int         sep;
        int         pos;
        kind = $urandom_range(0, 99);
        if (kind < 12)
        begin
            // noise: any command byte, any body
            if ($urandom_range(0, 1) == 0)
                frame_q.push_back(8'($urandom_range(0, 255)));
            else
                frame_q.push_back(CHR_PASCAL);
            repeat ($urandom_range(0, 8)) frame_q.push_back(8'($urandom_range(0, 255)));
        end
        else
        begin
            case ($urandom_range(0, 2))
                0:       frame_q.push_back(CHR_SNAKE);
                1:       frame_q.push_back(CHR_CAMEL);
                default: frame_q.push_back(CHR_PASCAL);
            endcase
            if (kind >= 95)
                n_words = $urandom_range(4, 12);
            else
                n_words = $urandom_range(1, (regs_now.max_words >= 6) ? 7
                                            : int'(regs_now.max_words) + 1);
            for (int w = 0; w < n_words; w++)
            begin
                sep = $urandom_range(0, 2);
                if (w > 0 && sep == 0)
                    frame_q.push_back(CHR_US);
                else if (w > 0 && sep == 1)
                    frame_q.push_back(CHR_SP);
                frame_q.push_back(pick_letter((w > 0 && sep == 2) || $urandom_range(0, 1) == 1));
                if (kind >= 95)
                    wlen = regs_now.max_word_len;
                else if ($urandom_range(0, 6) == 0)
                    wlen = int'(regs_now.max_word_len) + 1;
                else
                    wlen = $urandom_range(1, regs_now.max_word_len);
                for (int k = 1; k < wlen; k++)
                    frame_q.push_back(pick_letter(1'b0));
            end
            if (kind < 22)
            begin
                // broken frame: damage one place in the body
                pos = $urandom_range(1, frame_q.size() - 1);
                case ($urandom_range(0, 3))
                    0:       frame_q[pos] = 8'($urandom_range(0, 255));
                    1:       frame_q.insert(pos, CHR_US);
                    2:       frame_q.push_back(CHR_SP);
                    default: frame_q[pos] = CHR_ZERO + 8'($urandom_range(0, 9));
                endcase
            end
        end
        frame_q.push_back(regs_now.end_marker);
        foreach (frame_q[i])
            send_byte(frame_q[i]);
    endtask

    // output side stalls on a pattern that changes every so often
    initial
    begin : receiver
        int stall_tick;
        int stall_mode;
        stall_tick   = 0;
        stall_mode   = 0;
        out_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            stall_tick++;
            if (stall_tick % 150 == 0)
                stall_mode = $urandom_range(0, 2);
            case (stall_mode)
                0:       out_ch.ready <= 1'b1;
                1:       out_ch.ready <= ($urandom_range(0, 3) != 0);
                default: out_ch.ready <= ((stall_tick % 7) < 4);
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            words_checked++;
            if (awaited_words.size() == 0)
                flag_error($sformatf("unexpected word %h last %b",
                                     out_ch.out_byte, out_ch.out_last));
            else
            begin
                head_word = awaited_words.pop_front();
                if (head_word.data !== out_ch.out_byte || head_word.last !== out_ch.out_last)
                    flag_error($sformatf("word %0d: expected %h last %b, got %h last %b",
                                         words_checked, head_word.data, head_word.last,
                                         out_ch.out_byte, out_ch.out_last));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
            (psel && penable))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("identifier_case_converter regression: fail");
            $finish;
        end
    end

    initial
    begin : stimulus
        directed_row_t directed_rows [DIRECTED_COUNT];
        logic [7:0] end_val;
        logic [3:0] len_val;
        logic [4:0] min_val;
        logic [4:0] max_val;
        int         phase_start;
        int         n;

        // typed results are the error codes and one frame at the length limit
        directed_rows = '{
            '{1'b0, REG_END_MARKER,   8'h00, "",          "E01"},
            '{1'b0, REG_END_MARKER,   8'h00, "Xa",        "E01"},
            '{1'b0, REG_END_MARKER,   8'h00, "S",         "E00"},
            '{1'b0, REG_END_MARKER,   8'h00, "Pa\377",    "E00"},
            '{1'b0, REG_END_MARKER,   8'h00, "Sa_",       "E00"},
            '{1'b0, REG_END_MARKER,   8'h00, "SaB c",     ""},
            '{1'b0, REG_END_MARKER,   8'h00, "CzY",       ""},
            '{1'b1, REG_MAX_WORD_LEN, 8'd1,  "",          ""},
            '{1'b1, REG_MIN_WORDS,    8'd2,  "",          ""},
            '{1'b1, REG_MAX_WORDS,    8'd2,  "",          ""},
            '{1'b0, REG_END_MARKER,   8'h00, "Sab",       "E00"},
            '{1'b0, REG_END_MARKER,   8'h00, "Sa",        "E00"},
            '{1'b0, REG_END_MARKER,   8'h00, "PaBC",      "E00"},
            '{1'b0, REG_END_MARKER,   8'h00, "PaB",       "PAB"}
        };

        rst_n         = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        in_ch.valid   = 1'b0;
        in_ch.in_byte = '0;
        typed_row     = 1'b0;
        inputs_sent   = 0;
        words_checked = 0;
        frames_done   = 0;
        error_frames  = 0;
        mismatches    = 0;
        idle_cycles   = 0;
        burst_left    = 0;
        settings_used = 1;
        regs_now      = '{RST_END_MARKER, RST_MAX_WORD_LEN, RST_MIN_WORDS, RST_MAX_WORDS};
        conv_mode     = MODE_PASCAL;
        clear_frame();

        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[r])
        begin
            if (directed_rows[r].is_write)
            begin
                wait_idle();
                write_reg(directed_rows[r].reg_sel, directed_rows[r].reg_val);
            end
            else
            begin
                n = directed_rows[r].typed_result.len();
                typed_row = (n != 0);
                for (int k = 0; k < n; k++)
                    awaited_words.push_back('{directed_rows[r].typed_result[k], k == n - 1});
                for (int k = 0; k < directed_rows[r].frame_text.len(); k++)
                    send_byte(directed_rows[r].frame_text[k]);
                send_byte(regs_now.end_marker);
                typed_row = 1'b0;
            end
        end
        settings_used++;

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            if (p < FIXED_PHASES)
            begin
                end_val = FIXED_END[p];
                len_val = FIXED_LEN[p];
                min_val = FIXED_MIN[p];
                max_val = FIXED_MAX[p];
            end
            else
            begin
                end_val = 8'($urandom_range(0, 255));
                len_val = 4'($urandom_range(1, 15));
                min_val = 5'($urandom_range(1, 3));
                max_val = 5'($urandom_range(1, 31));
            end
            wait_idle();
            write_reg(REG_END_MARKER, end_val);
            write_reg(REG_MAX_WORD_LEN, 8'(len_val));
            write_reg(REG_MIN_WORDS, 8'(min_val));
            write_reg(REG_MAX_WORDS, 8'(max_val));
            settings_used++;
            phase_start = inputs_sent;
            while (inputs_sent - phase_start < PHASE_ITEMS)
                send_frame();
        end

        wait_idle();
        if (awaited_words.size() != 0)
            flag_error($sformatf("%0d words never arrived", awaited_words.size()));

        $display("summary: %0d input words in %0d frames, %0d of them error replies",
                 inputs_sent, frames_done, error_frames);
        $display("summary: %0d output words checked over %0d register settings, %0d failures",
                 words_checked, settings_used, mismatches);
        if (mismatches == 0)
            $display("identifier_case_converter regression: pass");
        else
            $display("identifier_case_converter regression: fail");
        $finish;
    end

endmodule
